@@ sv/joystick_sector_relay_decoder_assert.svh @@
// Assertion macros for the joystick sector relay decoder.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef JOYSTICK_SECTOR_RELAY_DECODER_ASSERT_SVH
`define JOYSTICK_SECTOR_RELAY_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSRD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsrd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define JSRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsrd next-cycle check failed");

`endif

@@ sv/jsrd_pkg.sv @@
// Shared types and constants of the joystick sector relay decoder.
// Used by every module of the block; depends on nothing else.
package jsrd_pkg;

  // Sector and relay geometry.
  localparam int SECTOR_COUNT = 12;
  localparam int RELAY_COUNT  = 6;
  localparam int SECTOR_W     = 4;
  localparam int PATTERN_W    = 6;

  // Configuration port sizing.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_ENTER  = 2'd1;
  localparam logic [1:0] REG_EXIT   = 2'd2;

  // Register reset values.
  localparam logic [7:0] CENTER_RESET = 8'd127;
  localparam logic [7:0] ENTER_RESET  = 8'd60;
  localparam logic [7:0] EXIT_RESET   = 8'd40;

  // Sectors with a fixed meaning.
  localparam logic [SECTOR_W-1:0] SECTOR_REST = SECTOR_W'(SECTOR_COUNT / 2);
  localparam logic [SECTOR_W-1:0] SECTOR_LAST = SECTOR_W'(SECTOR_COUNT - 1);

  // Relay pattern for each sector, and the mask of relays that exist.
  localparam logic [7:0] RELAY_TABLE [SECTOR_COUNT] = '{
    8'h08, 8'h18, 8'h10, 8'h30, 8'h20, 8'h21,
    8'h01, 8'h03, 8'h02, 8'h06, 8'h04, 8'h0C
  };
  localparam logic [7:0] RELAY_MASK = 8'((1 << RELAY_COUNT) - 1);

  // One input beat.
  typedef struct packed {
    logic [7:0] axis_x;
    logic [7:0] axis_y;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [PATTERN_W-1:0] relay_pattern;
    logic                 is_active;
    logic [SECTOR_W-1:0]  sector;
  } out_beat_t;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] center_value;
    logic [7:0] enter_threshold;
    logic [7:0] exit_threshold;
  } cfg_t;

endpackage

@@ sv/joystick_sector_relay_decoder.sv @@
// Top level of the joystick sector relay decoder.
// Instantiates jsrd_cfg, jsrd_in_stage, jsrd_core and jsrd_out_stage;
// uses jsrd_pkg and the assertion macros in joystick_sector_relay_decoder_assert.svh.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one joystick sample
//   (axis_x, axis_y) per beat. Output channel out_valid / out_stall / out_data
//   returns exactly one beat per sample: relay_pattern, is_active and sector.
//   The APB-style port writes center_value (0x0), enter_threshold (0x4) and
//   exit_threshold (0x8); write only while no sample is in flight.
// Timing:
//   A sample accepted into the input register is decoded combinationally;
//   its result is loaded into the output register, raising out_valid, as soon
//   as that register is free. One sample per cycle is sustained while out_stall
//   is low; the hysteresis flag update in the result register sets that pace.
// Reset:
//   rst (synchronous, active high) empties both registers, clears the
//   hysteresis flag and restores the register defaults 127, 60 and 40.
// Stall:
//   While out_stall holds a result, one further sample is still taken into
//   the input register; after that in_stall rises until the result moves on.
`include "joystick_sector_relay_decoder_assert.svh"

module joystick_sector_relay_decoder import jsrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_beat_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  logic      advance;
  logic      held_valid;
  in_beat_t  held_data;
  out_beat_t result;
  logic      active_flag;
  logic      out_quiet;
  logic      out_named;

  // Configuration registers.
  jsrd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  jsrd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  // Combinational decode.
  jsrd_core u_core (
    .sample      (held_data),
    .cfg         (cfg),
    .active_flag (active_flag),
    .result      (result)
  );

  // Result register and hysteresis flag.
  jsrd_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .held_valid  (held_valid),
    .result      (result),
    .advance     (advance),
    .active_flag (active_flag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // Shape of the shown result beat, for the checks below.
  assign out_quiet = out_data.relay_pattern == '0 && out_data.sector == '0;
  assign out_named = out_data.sector <= SECTOR_LAST &&
                     ($countones(out_data.relay_pattern) == 1 ||
                      $countones(out_data.relay_pattern) == 2);

  // An inactive result carries no sector and drives no relay.
  `JSRD_ASSERT_IMPLY(a_inactive_quiet, out_valid && !out_data.is_active, out_quiet)

  // An active result names a real sector and drives one or two neighboring relays.
  `JSRD_ASSERT_IMPLY(a_active_pattern, out_valid && out_data.is_active, out_named)

  // The shown result always agrees with the stored hysteresis flag.
  `JSRD_ASSERT_IMPLY(a_flag_matches, out_valid, out_data.is_active == active_flag)

  // A held sample with a free result register is moved on at the next edge.
  `JSRD_ASSERT_NEXT(a_in_drains, held_valid && !out_valid, out_valid)

endmodule

@@ sv/jsrd_cfg.sv @@
// APB-style configuration registers of the joystick sector relay decoder.
// Depends on jsrd_pkg for register indexes, reset values and cfg_t.
module jsrd_cfg import jsrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_value    <= CENTER_RESET;
      cfg.enter_threshold <= ENTER_RESET;
      cfg.exit_threshold  <= EXIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CENTER: cfg.center_value    <= pwdata[7:0];
        REG_ENTER:  cfg.enter_threshold <= pwdata[7:0];
        REG_EXIT:   cfg.exit_threshold  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (reg_idx)
      REG_CENTER: prdata = PDATA_W'(cfg.center_value);
      REG_ENTER:  prdata = PDATA_W'(cfg.enter_threshold);
      REG_EXIT:   prdata = PDATA_W'(cfg.exit_threshold);
      default:    prdata = '0;
    endcase
  end

endmodule

@@ sv/jsrd_in_stage.sv @@
// Input register of the joystick sector relay decoder.
// Holds one accepted beat until the result stage takes it; uses jsrd_pkg.
module jsrd_in_stage import jsrd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  input  logic     advance,
  output logic     held_valid,
  output in_beat_t held_data
);

  logic take;

  // The register frees up when empty or when the result stage loads it.
  assign take     = !held_valid || advance;
  assign in_stall = !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      held_data <= in_data;
    end
  end

endmodule

@@ sv/jsrd_core.sv @@
// Combinational decode of one sample: distance hysteresis and sector lookup.
// Depends on jsrd_pkg for the relay table, sector constants and beat types.
module jsrd_core import jsrd_pkg::*; (
  input  in_beat_t  sample,
  input  cfg_t      cfg,
  input  logic      active_flag,
  output out_beat_t result
);

  logic signed [8:0]  dx, dy;
  logic [7:0]         ax, ay;
  logic [15:0]        dx_sq, dy_sq;
  logic [16:0]        dist_sq;
  logic [8:0]         enter_p1;
  logic [16:0]        enter_sq;
  logic [15:0]        exit_sq;
  logic               active_next;
  logic [1:0]         quad;
  logic [15:0]        uu, vv;
  logic [17:0]        uu3, vv3;
  logic [1:0]         third;
  logic [SECTOR_W-1:0] sector_raw;
  logic [SECTOR_W-1:0] sector;

  // Offsets from the center and their magnitudes.
  assign dx = $signed({1'b0, sample.axis_x}) - $signed({1'b0, cfg.center_value});
  assign dy = $signed({1'b0, sample.axis_y}) - $signed({1'b0, cfg.center_value});
  assign ax = dx[8] ? 8'(-dx) : dx[7:0];
  assign ay = dy[8] ? 8'(-dy) : dy[7:0];

  // Squared distance against squared thresholds.
  assign dx_sq    = 16'(ax) * 16'(ax);
  assign dy_sq    = 16'(ay) * 16'(ay);
  assign dist_sq  = 17'(dx_sq) + 17'(dy_sq);
  assign enter_p1 = {1'b0, cfg.enter_threshold} + 9'd1;
  assign enter_sq = 17'(enter_p1) * 17'(enter_p1);
  assign exit_sq  = 16'(cfg.exit_threshold) * 16'(cfg.exit_threshold);

  // Hysteresis: enter above the enter threshold, leave below the exit one.
  always_comb begin
    if (!active_flag) begin
      active_next = (dist_sq >= enter_sq);
    end else begin
      active_next = !(dist_sq < 17'(exit_sq));
    end
  end

  // Quadrant of the reversed vector, measured clockwise from +y.
  // The squares of the two in-quadrant coordinates are the axis squares.
  always_comb begin
    if (dx <= 0 && dy < 0) begin
      quad = 2'd0;
      uu   = dx_sq;
      vv   = dy_sq;
    end else if (dx < 0) begin
      quad = 2'd1;
      uu   = dy_sq;
      vv   = dx_sq;
    end else if (dy > 0) begin
      quad = 2'd2;
      uu   = dx_sq;
      vv   = dy_sq;
    end else begin
      quad = 2'd3;
      uu   = dy_sq;
      vv   = dx_sq;
    end
  end

  // Which 30 degree third of the quadrant: tan 30 and tan 60 tests.
  assign uu3 = {1'b0, uu, 1'b0} + 18'(uu);
  assign vv3 = {1'b0, vv, 1'b0} + 18'(vv);

  always_comb begin
    if (uu3 < 18'(vv)) begin
      third = 2'd0;
    end else if (18'(uu) < vv3) begin
      third = 2'd1;
    end else begin
      third = 2'd2;
    end
  end

  assign sector_raw = SECTOR_W'({quad, 1'b0}) + SECTOR_W'(quad) + SECTOR_W'(third);

  // No deflection reads as straight up; straight down clamps to the last sector.
  always_comb begin
    if (dx == 0 && dy == 0) begin
      sector = SECTOR_REST;
    end else if (dx == 0 && dy < 0) begin
      sector = SECTOR_LAST;
    end else if (sector_raw > SECTOR_LAST) begin
      sector = SECTOR_LAST;
    end else begin
      sector = sector_raw;
    end
  end

  // Result fields; everything is zero while inactive.
  always_comb begin
    result.is_active = active_next;
    if (active_next) begin
      result.sector        = sector;
      result.relay_pattern = PATTERN_W'(RELAY_TABLE[sector] & RELAY_MASK);
    end else begin
      result.sector        = '0;
      result.relay_pattern = '0;
    end
  end

endmodule

@@ sv/jsrd_out_stage.sv @@
// Result register and hysteresis state of the joystick sector relay decoder.
// Depends on jsrd_pkg for out_beat_t.
module jsrd_out_stage import jsrd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      held_valid,
  input  out_beat_t result,
  output logic      advance,
  output logic      active_flag,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic load;

  // The result register moves when empty or when its beat is taken.
  assign advance = !out_valid || !out_stall;
  assign load    = advance && held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      active_flag <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= held_valid;
      end
      if (load) begin
        active_flag <= result.is_active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule
